[rtl/kchd_pkg.sv]
// Shared types and constants for the key combo hold detector.
// No dependencies; used by kchd_combo_slot and key_combo_hold_detector.
package kchd_pkg;

  localparam int NumCombosDef = 4;
  localparam int NumKeysDef   = 16;
  localparam int RegCombos    = 4;

  localparam int KeyW    = 4;
  localparam int KeysW   = 16;
  localparam int HoldW   = 16;
  localparam int TimeW   = 32;
  localparam int CountW  = 3;
  localparam int CfgW    = 24;
  localparam int CfgIdxW = 3;
  localparam int TrigW   = 4;

  localparam logic [CfgIdxW-1:0] RegComboCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCombo0     = 3'd1;

  localparam logic signed [TrigW-1:0] NoTrig = -4'sd1;

  typedef enum logic {
    ActUpdate = 1'b0,
    ActQuery  = 1'b1
  } action_e;

  typedef struct packed {
    action_e           action;
    logic [KeysW-1:0]  key_states;
    logic [TimeW-1:0]  now_ms;
    logic [KeyW-1:0]   query_key_a;
    logic [KeyW-1:0]   query_key_b;
  } in_item_t;

  typedef struct packed {
    logic signed [TrigW-1:0] triggered_index;
    logic                    query_triggered;
  } out_item_t;

  // packing of a combo register: hold in 23:8, second key 7:4, first key 3:0
  typedef struct packed {
    logic [HoldW-1:0] hold;
    logic [KeyW-1:0]  key_b;
    logic [KeyW-1:0]  key_a;
  } combo_cfg_t;

  typedef struct packed {
    logic wipe;
    logic step_update;
    logic query_clear;
  } slot_ctrl_t;

endpackage

[rtl/key_combo_hold_detector.sv]
// Top level of the key combo hold detector: config registers, item pipeline.
// Depends on kchd_pkg and kchd_combo_slot.
//
//  channel | signals                            | direction
//  in      | in_valid_i, in_stall_o, in_item_i  | update or query item in
//  out     | out_valid_o, out_stall_i, out_item_o | one result item per input
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i    | register writes
//
// One item per cycle while the output is not stalled; out_valid_o rises once the
// item has passed the input register, then evaluation of all combo slots into the
// result register.
// Reset clears combo state, config registers, valid flags and last_triggered (-1) at once.
// A stalled output holds its item; the input register keeps taking items
// until it is full behind the stalled result.
module key_combo_hold_detector #(
  parameter int NumCombos = kchd_pkg::NumCombosDef,
  parameter int NumKeys   = kchd_pkg::NumKeysDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  kchd_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output kchd_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [kchd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kchd_pkg::CfgW-1:0]     cfg_data_i
);
  import kchd_pkg::*;

  localparam logic [CountW-1:0] MaxCount = CountW'(NumCombos);

  logic [CountW-1:0] count_q;
  combo_cfg_t        cfg_q [RegCombos];
  logic [CountW-1:0] used_cnt;

  logic     in_vld_q;
  in_item_t in_q;
  logic     out_vld_q;
  out_item_t out_q, out_d;
  logic signed [TrigW-1:0] last_q, last_d;
  logic     advance, is_update, is_query, count_wr;

  combo_cfg_t       slot_cfg  [NumCombos];
  slot_ctrl_t       slot_ctrl [NumCombos];
  logic [NumCombos-1:0] in_use, hit, first_hit, det, trig;
  logic             found, qres;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign is_update  = advance && (in_q.action == ActUpdate);
  assign is_query   = advance && (in_q.action == ActQuery);
  assign count_wr   = cfg_we_i && (cfg_idx_i == RegComboCount);
  assign used_cnt   = (count_q > MaxCount) ? MaxCount : count_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int j = 0; j < RegCombos; j++) cfg_q[j] <= '0;
    end else if (cfg_we_i) begin
      if (count_wr) count_q <= cfg_data_i[CountW-1:0];
      for (int j = 0; j < RegCombos; j++) begin
        if (cfg_idx_i == RegCombo0 + CfgIdxW'(j)) cfg_q[j] <= combo_cfg_t'(cfg_data_i);
      end
    end
  end

  for (genvar i = 0; i < NumCombos; i++) begin : g_slot
    if (i < RegCombos) begin : g_reg
      assign slot_cfg[i] = cfg_q[i];
      assign slot_ctrl[i].wipe = count_wr ||
                                 (cfg_we_i && cfg_idx_i == RegCombo0 + CfgIdxW'(i));
    end else begin : g_fixed
      assign slot_cfg[i]       = '0;
      assign slot_ctrl[i].wipe = count_wr;
    end
    assign in_use[i]                = CountW'(i) < used_cnt;
    assign slot_ctrl[i].step_update = is_update;
    assign slot_ctrl[i].query_clear = is_query && first_hit[i];

    kchd_combo_slot #(.NumKeys(NumKeys)) u_slot (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (slot_cfg[i]),
      .in_use_i    (in_use[i]),
      .ctrl_i      (slot_ctrl[i]),
      .item_i      (in_q),
      .query_hit_o (hit[i]),
      .detected_o  (det[i]),
      .trig_o      (trig[i])
    );
  end

  // lowest matching combo answers a query; an update reports the highest triggered combo
  always_comb begin
    found     = 1'b0;
    qres      = 1'b0;
    first_hit = '0;
    last_d    = last_q;
    for (int i = 0; i < NumCombos; i++) begin
      if (hit[i] && !found) begin
        found        = 1'b1;
        first_hit[i] = 1'b1;
        qres         = det[i];
      end
    end
    if (is_update) begin
      last_d = NoTrig;
      for (int i = 0; i < NumCombos; i++) begin
        if (trig[i]) last_d = TrigW'(i);
      end
    end
    out_d.triggered_index = last_d;
    out_d.query_triggered = is_query && qres;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      last_q    <= NoTrig;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (count_wr) begin
        last_q <= NoTrig;
      end else begin
        last_q <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_item_i;
    if (advance) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

[rtl/kchd_combo_slot.sv]
// One combo slot: active flag, start time and detected mark with hold check.
// Depends on kchd_pkg.
module kchd_combo_slot #(
  parameter int NumKeys = kchd_pkg::NumKeysDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kchd_pkg::combo_cfg_t   cfg_i,
  input  logic                   in_use_i,
  input  kchd_pkg::slot_ctrl_t   ctrl_i,
  input  kchd_pkg::in_item_t     item_i,
  output logic                   query_hit_o,
  output logic                   detected_o,
  output logic                   trig_o
);
  import kchd_pkg::*;

  localparam logic [KeyW:0] KeyLimit = (KeyW+1)'(NumKeys);

  logic             active_q, active_d;
  logic             det_q, det_d;
  logic [TimeW-1:0] start_q, start_d;
  logic             down_a, down_b, both_down;
  logic [TimeW-1:0] elapsed;

  assign down_a    = ({1'b0, cfg_i.key_a} < KeyLimit) && item_i.key_states[cfg_i.key_a];
  assign down_b    = ({1'b0, cfg_i.key_b} < KeyLimit) && item_i.key_states[cfg_i.key_b];
  assign both_down = down_a && down_b;
  assign elapsed   = item_i.now_ms - start_q;

  assign trig_o = in_use_i && both_down && active_q && !det_q &&
                  (elapsed >= TimeW'(cfg_i.hold));

  assign query_hit_o = in_use_i &&
    ((cfg_i.key_a == item_i.query_key_a && cfg_i.key_b == item_i.query_key_b) ||
     (cfg_i.key_a == item_i.query_key_b && cfg_i.key_b == item_i.query_key_a));
  assign detected_o = det_q;

  always_comb begin
    active_d = active_q;
    det_d    = det_q;
    start_d  = start_q;
    if (ctrl_i.wipe) begin
      active_d = 1'b0;
      det_d    = 1'b0;
    end else if (ctrl_i.step_update && in_use_i) begin
      if (!both_down) begin
        active_d = 1'b0;
        det_d    = 1'b0;
      end else if (!active_q) begin
        active_d = 1'b1;
        det_d    = 1'b0;
        start_d  = item_i.now_ms;
      end else if (trig_o) begin
        det_d = 1'b1;
      end
    end else if (ctrl_i.query_clear) begin
      det_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      det_q    <= 1'b0;
    end else begin
      active_q <= active_d;
      det_q    <= det_d;
    end
  end

  // start time is only read while active, so it needs no reset
  always_ff @(posedge clk_i) begin
    start_q <= start_d;
  end

endmodule
